// ===== hw/rtl/oalm_pkg.sv =====
`default_nettype none

package oalm_pkg;

   localparam int TABLE_DEPTH = 4096;
   localparam int ADDR_W      = $clog2(TABLE_DEPTH);

   localparam int ID_W   = 12;
   localparam int TIME_W = 63;
   localparam int LAT_W  = 64;
   localparam int SYM_W  = 16;
   localparam int KIND_W = 8;

   localparam logic ACT_REQUEST  = 1'b0;
   localparam logic ACT_RESPONSE = 1'b1;

   typedef logic [ADDR_W-1:0] addr_type;

   typedef struct packed {
      logic              valid;
      logic [TIME_W-1:0] stamp;
      logic [SYM_W-1:0]  symbol;
      logic [KIND_W-1:0] kind;
   } entry_type;

   typedef struct packed {
      logic      en;
      addr_type  addr;
      entry_type data;
   } tbl_wr_type;

   typedef struct packed {
      logic     en;
      addr_type addr;
   } tbl_rd_type;

   typedef enum logic [1:0] {
      ST_INIT,
      ST_IDLE,
      ST_LOOKUP
   } state_type;

endpackage

`default_nettype wire

// ===== hw/rtl/oalm_table.sv =====
`default_nettype none

module oalm_table (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire oalm_pkg::tbl_wr_type wr,
   input  wire oalm_pkg::tbl_rd_type rd,
   output oalm_pkg::entry_type       rd_data,
   output logic                      ready
);

   oalm_pkg::entry_type mem [oalm_pkg::TABLE_DEPTH];
   oalm_pkg::entry_type rd_data_ff;

   oalm_pkg::addr_type  clr_addr_ff, clr_addr_in;
   logic                clr_active_ff, clr_active_in;

   logic                port_en;
   oalm_pkg::addr_type  port_addr;
   oalm_pkg::entry_type port_data;

   // one entry per cycle is wiped after reset
   always_comb begin
      clr_addr_in   = clr_addr_ff;
      clr_active_in = clr_active_ff;
      if (clr_active_ff) begin
         clr_addr_in = clr_addr_ff + oalm_pkg::addr_type'(1);
         if (clr_addr_ff == oalm_pkg::addr_type'(oalm_pkg::TABLE_DEPTH - 1)) begin
            clr_active_in = 1'b0;
         end
      end
   end

   always_comb begin
      if (clr_active_ff) begin
         port_en   = 1'b1;
         port_addr = clr_addr_ff;
         port_data = '0;
      end else begin
         port_en   = wr.en;
         port_addr = wr.addr;
         port_data = wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_active_ff <= 1'b1;
         clr_addr_ff   <= '0;
      end else begin
         clr_active_ff <= clr_active_in;
         clr_addr_ff   <= clr_addr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (port_en) begin
         mem[port_addr] <= port_data;
      end
      if (rd.en) begin
         rd_data_ff <= mem[rd.addr];
      end
   end

   assign rd_data = rd_data_ff;
   assign ready   = !clr_active_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/order_ack_latency_matcher_unit.sv =====
// channel  | ports                                      | handshake
// ---------+--------------------------------------------+------------------------
// request  | req_action req_order_id req_event_time     | start & !busy
//          | req_symbol_code req_kind_code              |
// result   | rsp_request_time rsp_latency               | rsp_valid, one cycle,
//          | rsp_matched_symbol rsp_matched_kind        | no backpressure
//          | rsp_matched_id                             |
//
// A request event writes its entry into the pending table at the accept edge.
// A response event starts a registered read of the pending table, followed by
// the invalidating write-back in the lookup state; a hit shows up on rsp_valid
// the cycle after the lookup.
// After reset, busy stays high while the 4096 table entries are wiped one per
// cycle, and until the unit then leaves the init state.
// The result side cannot stall; each result is present for one cycle only.
`default_nettype none

module order_ack_latency_matcher_unit (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic                          req_action,
   input  wire logic [oalm_pkg::ID_W-1:0]     req_order_id,
   input  wire logic [oalm_pkg::TIME_W-1:0]   req_event_time,
   input  wire logic [oalm_pkg::SYM_W-1:0]    req_symbol_code,
   input  wire logic [oalm_pkg::KIND_W-1:0]   req_kind_code,
   output logic                               rsp_valid,
   output logic [oalm_pkg::TIME_W-1:0]        rsp_request_time,
   output logic signed [oalm_pkg::LAT_W-1:0]  rsp_latency,
   output logic [oalm_pkg::SYM_W-1:0]         rsp_matched_symbol,
   output logic [oalm_pkg::KIND_W-1:0]        rsp_matched_kind,
   output logic [oalm_pkg::ID_W-1:0]          rsp_matched_id
);

   oalm_pkg::state_type  state_ff, state_in;

   logic [oalm_pkg::ID_W-1:0]   id_ff;
   logic [oalm_pkg::TIME_W-1:0] resp_time_ff;

   logic                              rsp_valid_ff, rsp_valid_in;
   logic [oalm_pkg::TIME_W-1:0]       rsp_time_ff;
   logic signed [oalm_pkg::LAT_W-1:0] rsp_latency_ff, rsp_latency_in;
   logic [oalm_pkg::SYM_W-1:0]        rsp_symbol_ff;
   logic [oalm_pkg::KIND_W-1:0]       rsp_kind_ff;
   logic [oalm_pkg::ID_W-1:0]         rsp_id_ff;

   oalm_pkg::tbl_wr_type tbl_wr;
   oalm_pkg::tbl_rd_type tbl_rd;
   oalm_pkg::entry_type  tbl_rd_data;
   logic                 tbl_ready;

   logic accept;
   logic in_range;
   logic hit;

   oalm_table u_table (
      .clock   (clock),
      .reset   (reset),
      .wr      (tbl_wr),
      .rd      (tbl_rd),
      .rd_data (tbl_rd_data),
      .ready   (tbl_ready)
   );

   assign accept   = start && !busy;
   assign in_range = 32'(req_order_id) < oalm_pkg::TABLE_DEPTH;
   assign hit      = (state_ff == oalm_pkg::ST_LOOKUP) && tbl_rd_data.valid;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         oalm_pkg::ST_INIT: begin
            if (tbl_ready) begin
               state_in = oalm_pkg::ST_IDLE;
            end
         end
         oalm_pkg::ST_IDLE: begin
            if (accept && in_range && req_action == oalm_pkg::ACT_RESPONSE) begin
               state_in = oalm_pkg::ST_LOOKUP;
            end
         end
         oalm_pkg::ST_LOOKUP: begin
            state_in = oalm_pkg::ST_IDLE;
         end
         default: begin
            state_in = oalm_pkg::ST_INIT;
         end
      endcase
   end

   always_comb begin
      busy          = (state_ff != oalm_pkg::ST_IDLE);
      tbl_wr        = '0;
      tbl_rd        = '0;
      case (state_ff)
         oalm_pkg::ST_IDLE: begin
            if (accept && in_range) begin
               if (req_action == oalm_pkg::ACT_REQUEST) begin
                  tbl_wr.en          = 1'b1;
                  tbl_wr.addr        = oalm_pkg::addr_type'(req_order_id);
                  tbl_wr.data.valid  = 1'b1;
                  tbl_wr.data.stamp  = req_event_time;
                  tbl_wr.data.symbol = req_symbol_code;
                  tbl_wr.data.kind   = req_kind_code;
               end else begin
                  tbl_rd.en   = 1'b1;
                  tbl_rd.addr = oalm_pkg::addr_type'(req_order_id);
               end
            end
         end
         oalm_pkg::ST_LOOKUP: begin
            // matched entry is retired
            if (hit) begin
               tbl_wr.en   = 1'b1;
               tbl_wr.addr = oalm_pkg::addr_type'(id_ff);
            end
         end
         default: begin
         end
      endcase
   end

   assign rsp_valid_in   = hit;
   assign rsp_latency_in = signed'({1'b0, resp_time_ff} - {1'b0, tbl_rd_data.stamp});

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= oalm_pkg::ST_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         id_ff        <= req_order_id;
         resp_time_ff <= req_event_time;
      end
      if (hit) begin
         rsp_time_ff    <= tbl_rd_data.stamp;
         rsp_latency_ff <= rsp_latency_in;
         rsp_symbol_ff  <= tbl_rd_data.symbol;
         rsp_kind_ff    <= tbl_rd_data.kind;
         rsp_id_ff      <= id_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_request_time   = rsp_time_ff;
   assign rsp_latency        = rsp_latency_ff;
   assign rsp_matched_symbol = rsp_symbol_ff;
   assign rsp_matched_kind   = rsp_kind_ff;
   assign rsp_matched_id     = rsp_id_ff;

   a_no_accept_before_clear: assert property (@(posedge clock) disable iff (reset)
      !tbl_ready |-> busy)
      else $error("request accepted while table clear in progress");

   a_result_follows_lookup: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff) == oalm_pkg::ST_LOOKUP)
      else $error("result strobe without a preceding lookup");

   a_hit_retires_entry: assert property (@(posedge clock) disable iff (reset)
      hit |-> tbl_wr.en && !tbl_wr.data.valid
              && tbl_wr.addr == oalm_pkg::addr_type'(id_ff))
      else $error("matched entry not invalidated");

   a_result_single_cycle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for two cycles");

endmodule

`default_nettype wire

// ===== dv/order_ack_latency_matcher_unit_tb.sv =====
`default_nettype none

module order_ack_latency_matcher_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int   TABLE_DEPTH  = oalm_pkg::TABLE_DEPTH;
   localparam int   ID_W         = oalm_pkg::ID_W;
   localparam int   TIME_W       = oalm_pkg::TIME_W;
   localparam int   LAT_W        = oalm_pkg::LAT_W;
   localparam int   SYM_W        = oalm_pkg::SYM_W;
   localparam int   KIND_W       = oalm_pkg::KIND_W;
   localparam logic ACT_REQUEST  = oalm_pkg::ACT_REQUEST;
   localparam logic ACT_RESPONSE = oalm_pkg::ACT_RESPONSE;

   localparam int N_RANDOM    = 530;
   localparam int STALL_LIMIT = 20000;
   localparam logic [TIME_W-1:0] TIME_MAX = '1;

   typedef struct packed {
      logic [TIME_W-1:0] stamp;
      logic [LAT_W-1:0]  lat;
      logic [SYM_W-1:0]  symbol;
      logic [KIND_W-1:0] kind;
      logic [ID_W-1:0]   id;
   } match_type;

   typedef enum logic [1:0] {
      CHK_MODEL,
      CHK_NONE,
      CHK_HIT
   } row_check_type;

   typedef struct packed {
      logic              act;
      logic [ID_W-1:0]   id;
      logic [TIME_W-1:0] t;
      logic [SYM_W-1:0]  sym;
      logic [KIND_W-1:0] kind;
      row_check_type     chk;
      match_type         typed;
   } stim_row_type;

   // hand-typed results only for reset, extremes and the overwrite case
   localparam stim_row_type DIRECTED [23] = '{
      '{ACT_RESPONSE, 12'd0,    63'd1,    16'h0000, 8'h00, CHK_NONE, '0},
      '{ACT_RESPONSE, 12'hFFF,  TIME_MAX, 16'hFFFF, 8'hFF, CHK_NONE, '0},
      '{ACT_REQUEST,  12'd0,    63'd0,    16'h0000, 8'h00, CHK_NONE, '0},
      '{ACT_RESPONSE, 12'd0,    TIME_MAX, 16'h0000, 8'h00, CHK_HIT,
        '{63'd0, 64'h7FFF_FFFF_FFFF_FFFF, 16'h0000, 8'h00, 12'd0}},
      '{ACT_RESPONSE, 12'd0,    63'd5,    16'h0000, 8'h00, CHK_NONE, '0},
      '{ACT_REQUEST,  12'hFFF,  TIME_MAX, 16'hFFFF, 8'hFF, CHK_NONE, '0},
      '{ACT_RESPONSE, 12'hFFF,  63'd0,    16'h0000, 8'h00, CHK_HIT,
        '{TIME_MAX, 64'h8000_0000_0000_0001, 16'hFFFF, 8'hFF, 12'hFFF}},
      '{ACT_REQUEST,  12'd5,    63'd100,  16'h1234, 8'h56, CHK_MODEL, '0},
      '{ACT_REQUEST,  12'd5,    63'd200,  16'hABCD, 8'h9A, CHK_MODEL, '0},
      '{ACT_RESPONSE, 12'd5,    63'd250,  16'h0000, 8'h00, CHK_HIT,
        '{63'd200, 64'd50, 16'hABCD, 8'h9A, 12'd5}},
      '{ACT_REQUEST,  12'd7,    63'd1000, 16'h5555, 8'h55, CHK_MODEL, '0},
      '{ACT_RESPONSE, 12'd7,    63'd1000, 16'hAAAA, 8'hAA, CHK_MODEL, '0},
      '{ACT_REQUEST,  12'd8,    63'd5000, 16'hAAAA, 8'hAA, CHK_MODEL, '0},
      '{ACT_RESPONSE, 12'd8,    63'd4000, 16'h5555, 8'h55, CHK_MODEL, '0},
      '{ACT_REQUEST,  12'hAAA, 63'h2AAA_AAAA_AAAA_AAAA, 16'h5555, 8'h55, CHK_MODEL, '0},
      '{ACT_RESPONSE, 12'hAAA, 63'h5555_5555_5555_5555, 16'hAAAA, 8'hAA, CHK_MODEL, '0},
      '{ACT_REQUEST,  12'h555, 63'h5555_5555_5555_5555, 16'hAAAA, 8'hAA, CHK_MODEL, '0},
      '{ACT_RESPONSE, 12'h555, 63'h2AAA_AAAA_AAAA_AAAA, 16'h5555, 8'h55, CHK_MODEL, '0},
      '{ACT_REQUEST,  12'd9,    63'd10,   16'h0101, 8'h01, CHK_MODEL, '0},
      '{ACT_RESPONSE, 12'd9,    63'd20,   16'h0000, 8'h00, CHK_MODEL, '0},
      '{ACT_REQUEST,  12'd9,    63'd30,   16'h0202, 8'h02, CHK_MODEL, '0},
      '{ACT_RESPONSE, 12'd9,    63'd45,   16'h0000, 8'h00, CHK_MODEL, '0},
      '{ACT_RESPONSE, 12'd9,    63'd50,   16'h0000, 8'h00, CHK_MODEL, '0}
   };

   logic clock = 1'b0;
   logic reset;
   logic start;
   logic busy;
   logic req_action;
   logic [ID_W-1:0]   req_order_id;
   logic [TIME_W-1:0] req_event_time;
   logic [SYM_W-1:0]  req_symbol_code;
   logic [KIND_W-1:0] req_kind_code;
   logic rsp_valid;
   logic [TIME_W-1:0]       rsp_request_time;
   logic signed [LAT_W-1:0] rsp_latency;
   logic [SYM_W-1:0]        rsp_matched_symbol;
   logic [KIND_W-1:0]       rsp_matched_kind;
   logic [ID_W-1:0]         rsp_matched_id;

   // shadow of the pending-order table
   bit                open_valid  [TABLE_DEPTH];
   logic [TIME_W-1:0] open_stamp  [TABLE_DEPTH];
   logic [SYM_W-1:0]  open_symbol [TABLE_DEPTH];
   logic [KIND_W-1:0] open_kind   [TABLE_DEPTH];
   logic [ID_W-1:0]   live_ids[$];

   match_type due_matches[$];

   bit gaps_on = 1'b1;
   int errors = 0;
   int n_requests = 0;
   int n_responses = 0;
   int n_matches = 0;
   int n_checked = 0;
   int stall_cycles = 0;

   order_ack_latency_matcher_unit uut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_action         (req_action),
      .req_order_id       (req_order_id),
      .req_event_time     (req_event_time),
      .req_symbol_code    (req_symbol_code),
      .req_kind_code      (req_kind_code),
      .rsp_valid          (rsp_valid),
      .rsp_request_time   (rsp_request_time),
      .rsp_latency        (rsp_latency),
      .rsp_matched_symbol (rsp_matched_symbol),
      .rsp_matched_kind   (rsp_matched_kind),
      .rsp_matched_id     (rsp_matched_id)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // applies one event to the shadow table; returns 1 on a response hit
   function automatic bit book_event(input logic act, input logic [ID_W-1:0] id,
                                     input logic [TIME_W-1:0] t,
                                     input logic [SYM_W-1:0] sym,
                                     input logic [KIND_W-1:0] kind, output match_type m);
      int k;
      m = '0;
      if (act == ACT_REQUEST) begin
         n_requests++;
         if (!open_valid[id])
            live_ids.insert(live_ids.size(), id);
         open_valid[id]  = 1'b1;
         open_stamp[id]  = t;
         open_symbol[id] = sym;
         open_kind[id]   = kind;
         return 1'b0;
      end
      n_responses++;
      if (!open_valid[id])
         return 1'b0;
      m.stamp  = open_stamp[id];
      m.lat    = {1'b0, t} - {1'b0, open_stamp[id]};
      m.symbol = open_symbol[id];
      m.kind   = open_kind[id];
      m.id     = id;
      open_valid[id] = 1'b0;
      for (k = 0; k < live_ids.size(); k++) begin
         if (live_ids[k] == id) begin
            live_ids.delete(k);
            break;
         end
      end
      n_matches++;
      return 1'b1;
   endfunction

   function automatic logic [ID_W-1:0] pick_id();
      int r;
      r = $urandom_range(99);
      if (r < 45)
         return ID_W'($urandom_range(15));
      if (r < 55) begin
         case ($urandom_range(3))
            0: return '0;
            1: return '1;
            2: return ID_W'(TABLE_DEPTH / 2);
            default: return ID_W'(TABLE_DEPTH / 2 - 1);
         endcase
      end
      return ID_W'($urandom_range(TABLE_DEPTH - 1));
   endfunction

   // holds start high until the block takes the request, then books it
   task automatic issue_event(input logic act, input logic [ID_W-1:0] id,
                              input logic [TIME_W-1:0] t, input logic [SYM_W-1:0] sym,
                              input logic [KIND_W-1:0] kind, input row_check_type chk,
                              input match_type typed);
      match_type predicted;
      bit hit;
      if (gaps_on && $urandom_range(99) < 14) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      start           <= 1'b1;
      req_action      <= act;
      req_order_id    <= id;
      req_event_time  <= t;
      req_symbol_code <= sym;
      req_kind_code   <= kind;
      @(posedge clock);
      while (busy !== 1'b0)
         @(posedge clock);
      hit = book_event(act, id, t, sym, kind, predicted);
      if (chk == CHK_HIT)
         due_matches.insert(due_matches.size(), typed);
      else if (chk == CHK_MODEL && hit)
         due_matches.insert(due_matches.size(), predicted);
   endtask

   function automatic bit field_ok(input string name, input logic [LAT_W-1:0] want,
                                   input logic [LAT_W-1:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
         return 1'b0;
      end
      return 1'b1;
   endfunction

   always @(posedge clock) begin : check_results
      match_type want;
      bit ok;
      if (!reset && rsp_valid === 1'b1) begin
         if (due_matches.size() == 0) begin
            $display("%0t: unexpected result: expected none, actual id %h latency %h",
                     $time, rsp_matched_id, rsp_latency);
            errors++;
         end else begin
            want = due_matches.pop_front();
            ok = field_ok("request_time", LAT_W'(want.stamp), LAT_W'(rsp_request_time));
            ok &= field_ok("latency", want.lat, rsp_latency);
            ok &= field_ok("matched_symbol", LAT_W'(want.symbol), LAT_W'(rsp_matched_symbol));
            ok &= field_ok("matched_kind", LAT_W'(want.kind), LAT_W'(rsp_matched_kind));
            ok &= field_ok("matched_id", LAT_W'(want.id), LAT_W'(rsp_matched_id));
            if (!ok)
               errors++;
            n_checked++;
         end
      end
   end

   // covers the table wipe after reset as well as a hung handshake
   always @(posedge clock) begin
      if ((start === 1'b1 && busy === 1'b0) || rsp_valid === 1'b1) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("%0t: no request or result accepted for %0d cycles, %0d results outstanding",
                  $time, stall_cycles, due_matches.size());
         $display("Test completed with failures");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      int i;
      logic is_resp;
      logic [ID_W-1:0]   id;
      logic [TIME_W-1:0] t;
      int r;

      reset           <= 1'b1;
      start           <= 1'b0;
      req_action      <= ACT_REQUEST;
      req_order_id    <= '0;
      req_event_time  <= '0;
      req_symbol_code <= '0;
      req_kind_code   <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      for (i = 0; i < $size(DIRECTED); i++)
         issue_event(DIRECTED[i].act, DIRECTED[i].id, DIRECTED[i].t, DIRECTED[i].sym,
                     DIRECTED[i].kind, DIRECTED[i].chk, DIRECTED[i].typed);

      for (i = 0; i < N_RANDOM; i++) begin
         gaps_on = !(i >= 180 && i < 330);
         is_resp = ($urandom_range(99) < 50);
         if (is_resp && live_ids.size() != 0 && $urandom_range(99) < 75)
            id = live_ids[$urandom_range(live_ids.size() - 1)];
         else
            id = pick_id();
         r = $urandom_range(99);
         if (is_resp && open_valid[id] && r < 40)
            t = open_stamp[id] + TIME_W'($urandom_range(5000));
         else if (r < 55)
            t = TIME_W'($urandom_range(1000));
         else if (r < 65)
            t = TIME_MAX - TIME_W'($urandom_range(1000));
         else
            t = TIME_W'({$urandom(), $urandom()});
         issue_event(is_resp ? ACT_RESPONSE : ACT_REQUEST, id, t, SYM_W'($urandom()),
                     KIND_W'($urandom()), CHK_MODEL, '0);
      end
      start <= 1'b0;

      while (due_matches.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);

      $display("Sent %0d request events and %0d response events (directed and random).",
               n_requests, n_responses);
      $display("Checked %0d matched results; %0d responses found no pending order.",
               n_checked, n_responses - n_matches);
      if (errors == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

`default_nettype wire
